[rtl/generation_handle_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Handle allocator assertion macros
// Shared property shorthands for the handle allocator checks. Each macro
// expects signals named clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef GENERATION_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATION_HANDLE_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GHA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gha_pkg.sv]
// ----------------------------------------------------------------------------
// Handle allocator package
// Command and status codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package gha_pkg;

  // Parameter defaults
  localparam int SLOT_COUNT_DEF = 1024;
  localparam int REF_WIDTH_DEF  = 32;

  // Field widths
  localparam int CMD_W        = 2;
  localparam int SLOT_FIELD_W = 12;
  localparam int VER_W        = 32;
  localparam int REF_FIELD_W  = 32;
  localparam int STATUS_W     = 3;
  localparam int OUT_IDX_W    = 10;

  localparam int IN_TUSER_W  = CMD_W;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;

  // Width of one word of the used-slot bitmap
  localparam int BM_WORD_W = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

  typedef logic [STATUS_W-1:0] status_t;

  // Result status codes
  localparam status_t ST_OK    = 3'd0;
  localparam status_t ST_NULL  = 3'd1;
  localparam status_t ST_FULL  = 3'd2;
  localparam status_t ST_RANGE = 3'd3;
  localparam status_t ST_FREE  = 3'd4;
  localparam status_t ST_STALE = 3'd5;

endpackage

[rtl/generation_handle_allocator.sv]
// ----------------------------------------------------------------------------
// Generation handle allocator
// A null or out-of-range request goes from idle straight to the result
// state; release and lookup pass through a read and a check state, and
// allocate through the bitmap scan of 1 to BM_DEPTH + 1 words, the write
// and the version read. One request is in flight at a time; in_tready
// returns high as the result is registered. After reset a clearing pass
// zeroes the versions and the bitmap, with in_tready low.
// ----------------------------------------------------------------------------
// Slots live in three single-port-read memories: a used bitmap of 32-bit
// words, the slot versions and the stored references. Allocation scans the
// bitmap one word per cycle next-fit from a rotating start pointer.
// ----------------------------------------------------------------------------
module generation_handle_allocator #(
  parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
  parameter int REF_WIDTH  = gha_pkg::REF_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // slot_index[11:0], version[43:12], task_ref[75:44], zero fill above
  input  logic [gha_pkg::IN_TDATA_W-1:0]   in_tdata,
  // cmd[1:0]
  input  logic [gha_pkg::IN_TUSER_W-1:0]   in_tuser,
  // Result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[2:0], out_index[12:3], out_version[44:13], out_task_ref[76:45],
  // zero fill above
  output logic [gha_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int BW         = gha_pkg::BM_WORD_W;
  localparam int BOW        = $clog2(BW);
  localparam int IW         = $clog2(SLOT_COUNT);
  localparam int BM_DEPTH   = (SLOT_COUNT + BW - 1) / BW;
  localparam int BAW        = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int XW         = BAW + BOW;
  localparam int SCAN_TOTAL = BM_DEPTH + 1;
  localparam int SCW        = $clog2(SCAN_TOTAL + 1);
  localparam int LAST_BITS  = SLOT_COUNT - (BM_DEPTH - 1) * BW;
  localparam int RW         = (REF_WIDTH < gha_pkg::REF_FIELD_W) ? REF_WIDTH
                                                                  : gha_pkg::REF_FIELD_W;
  localparam int VW         = gha_pkg::VER_W;
  localparam int SFW        = gha_pkg::SLOT_FIELD_W;
  localparam int OIW        = gha_pkg::OUT_IDX_W;
  localparam int RFW        = gha_pkg::REF_FIELD_W;
  localparam int PAD_W      = gha_pkg::OUT_TDATA_W - gha_pkg::STATUS_W - OIW - VW - RFW;

  // Bits of the last bitmap word that lie past the end of the table.
  localparam logic [BW-1:0] LAST_PAD = {BW{1'b1}} << LAST_BITS;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_AWRITE = 3'd3;
  localparam logic [2:0] S_AVER   = 3'd4;
  localparam logic [2:0] S_HREAD  = 3'd5;
  localparam logic [2:0] S_HCHECK = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  // Memories
  logic [BW-1:0] bm_mem  [BM_DEPTH];
  logic [VW-1:0] ver_mem [SLOT_COUNT];
  logic [RW-1:0] ref_mem [SLOT_COUNT];

  logic [BW-1:0] bm_rd_r;
  logic [VW-1:0] ver_rd_r;
  logic [RW-1:0] ref_rd_r;

  logic          bm_we;
  logic [BAW-1:0] bm_wa, bm_ra;
  logic [BW-1:0] bm_wd;
  logic          ver_we;
  logic [IW-1:0] ver_wa, ver_ra;
  logic [VW-1:0] ver_wd;
  logic          ref_we;
  logic [IW-1:0] ref_wa, ref_ra;
  logic [RW-1:0] ref_wd;

  // Control and request registers
  logic [2:0]                 state_r, state_nxt;
  logic [IW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [gha_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [IW-1:0]              idx_r, idx_nxt;
  logic [VW-1:0]              ver_r, ver_nxt;
  logic [RW-1:0]              ref_r, ref_nxt;
  logic [IW-1:0]              start_r, start_nxt;
  logic [BAW-1:0]             scan_w_r, scan_w_nxt;
  logic [SCW-1:0]             issued_r, issued_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_first_r, pend_first_nxt;
  logic [BAW-1:0]             pend_w_r, pend_w_nxt;
  logic [IW-1:0]              slot_k_r, slot_k_nxt;
  logic [BAW-1:0]             alloc_w_r, alloc_w_nxt;
  logic [BW-1:0]              bm_mod_r, bm_mod_nxt;
  gha_pkg::status_t           res_status_r, res_status_nxt;
  logic [OIW-1:0]             res_idx_r, res_idx_nxt;
  logic [VW-1:0]              res_ver_r, res_ver_nxt;
  logic [RFW-1:0]             res_ref_r, res_ref_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [gha_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Request fields
  logic [SFW-1:0] in_slot;
  logic [VW-1:0]  in_ver;
  logic [RFW-1:0] in_ref;
  logic           in_range;

  // Scan evaluation
  logic [XW-1:0]  start_x, idx_x, k_x;
  logic [BW-1:0]  scan_pad, scan_low, scan_busy, free_1h;
  logic [BOW-1:0] free_bit;
  logic           scan_found;
  logic           h_used;

  assign in_slot  = in_tdata[SFW-1:0];
  assign in_ver   = in_tdata[SFW +: VW];
  assign in_ref   = in_tdata[SFW+VW +: RFW];
  assign in_range = 32'(in_slot) < 32'(SLOT_COUNT);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign start_x = XW'(start_r);
  assign idx_x   = XW'(idx_r);

  // The first word of a scan treats slots below the start pointer as taken;
  // they are looked at again when the scan wraps back to that word.
  assign scan_pad   = (pend_w_r == BAW'(BM_DEPTH - 1)) ? LAST_PAD : '0;
  assign scan_low   = pend_first_r ? ~({BW{1'b1}} << start_x[BOW-1:0]) : '0;
  assign scan_busy  = bm_rd_r | scan_pad | scan_low;
  assign free_1h    = ~scan_busy & (scan_busy + BW'(1));
  assign scan_found = pend_r && (scan_busy != {BW{1'b1}});

  always_comb begin
    free_bit = '0;
    for (int b = 0; b < BW; b++) begin
      if (free_1h[b]) begin
        free_bit = free_bit | BOW'(b);
      end
    end
  end

  assign k_x    = {pend_w_r, free_bit};
  assign h_used = bm_rd_r[idx_x[BOW-1:0]];

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    ver_nxt        = ver_r;
    ref_nxt        = ref_r;
    start_nxt      = start_r;
    scan_w_nxt     = scan_w_r;
    issued_nxt     = issued_r;
    pend_nxt       = pend_r;
    pend_first_nxt = pend_first_r;
    pend_w_nxt     = pend_w_r;
    slot_k_nxt     = slot_k_r;
    alloc_w_nxt    = alloc_w_r;
    bm_mod_nxt     = bm_mod_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ver_nxt    = res_ver_r;
    res_ref_nxt    = res_ref_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    bm_we  = 1'b0;
    bm_wa  = '0;
    bm_wd  = '0;
    bm_ra  = '0;
    ver_we = 1'b0;
    ver_wa = '0;
    ver_wd = '0;
    ver_ra = '0;
    ref_we = 1'b0;
    ref_wa = '0;
    ref_wd = '0;
    ref_ra = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ver_we = 1'b1;
        ver_wa = clr_cnt_r;
        bm_we  = 32'(clr_cnt_r) < 32'(BM_DEPTH);
        bm_wa  = BAW'(clr_cnt_r);
        if (clr_cnt_r == IW'(SLOT_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_tuser;
          idx_nxt        = IW'(in_slot);
          ver_nxt        = in_ver;
          ref_nxt        = in_ref[RW-1:0];
          res_status_nxt = gha_pkg::ST_OK;
          res_idx_nxt    = '0;
          res_ver_nxt    = '0;
          res_ref_nxt    = '0;
          if (in_tuser == gha_pkg::CMD_ALLOC) begin
            if (in_ref[RW-1:0] == '0) begin
              res_status_nxt = gha_pkg::ST_NULL;
              state_nxt      = S_RESP;
            end else begin
              scan_w_nxt = start_x[XW-1:BOW];
              issued_nxt = '0;
              pend_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
          end else if (!in_range) begin
            res_status_nxt = gha_pkg::ST_RANGE;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_HREAD;
          end
        end
      end
      S_SCAN: begin
        // Reads are issued every cycle; the word from the previous read is
        // checked at the same time. A hit stops the scan with no further read.
        if (scan_found) begin
          slot_k_nxt  = IW'(k_x);
          alloc_w_nxt = pend_w_r;
          bm_mod_nxt  = bm_rd_r | free_1h;
          pend_nxt    = 1'b0;
          state_nxt   = S_AWRITE;
        end else if (pend_r && (issued_r == SCW'(SCAN_TOTAL))) begin
          res_status_nxt = gha_pkg::ST_FULL;
          pend_nxt       = 1'b0;
          state_nxt      = S_RESP;
        end else begin
          bm_ra          = scan_w_r;
          pend_nxt       = 1'b1;
          pend_first_nxt = (issued_r == '0);
          pend_w_nxt     = scan_w_r;
          issued_nxt     = issued_r + 1'b1;
          scan_w_nxt     = (scan_w_r == BAW'(BM_DEPTH - 1)) ? '0 : scan_w_r + 1'b1;
        end
      end
      S_AWRITE: begin
        bm_we       = 1'b1;
        bm_wa       = alloc_w_r;
        bm_wd       = bm_mod_r;
        ref_we      = 1'b1;
        ref_wa      = slot_k_r;
        ref_wd      = ref_r;
        ver_ra      = slot_k_r;
        start_nxt   = (slot_k_r == IW'(SLOT_COUNT - 1)) ? '0 : slot_k_r + 1'b1;
        res_idx_nxt = OIW'(slot_k_r);
        state_nxt   = S_AVER;
      end
      S_AVER: begin
        res_ver_nxt = ver_rd_r;
        state_nxt   = S_RESP;
      end
      S_HREAD: begin
        bm_ra     = idx_x[XW-1:BOW];
        ver_ra    = idx_r;
        ref_ra    = idx_r;
        state_nxt = S_HCHECK;
      end
      S_HCHECK: begin
        if (!h_used) begin
          res_status_nxt = gha_pkg::ST_FREE;
        end else if (ver_rd_r != ver_r) begin
          res_status_nxt = gha_pkg::ST_STALE;
        end else if (cmd_r == gha_pkg::CMD_RELEASE) begin
          bm_we     = 1'b1;
          bm_wa     = idx_x[XW-1:BOW];
          bm_wd     = bm_rd_r & ~(BW'(1) << idx_x[BOW-1:0]);
          ver_we    = 1'b1;
          ver_wa    = idx_r;
          ver_wd    = ver_rd_r + 1'b1;
          start_nxt = idx_r;
        end else begin
          // Lookup, and the unused fourth command code, which decodes as lookup.
          res_ref_nxt = RFW'(ref_rd_r);
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{PAD_W{1'b0}}, res_ref_r, res_ver_r, res_idx_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      start_r     <= '0;
      pend_r      <= 1'b0;
      issued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      start_r     <= start_nxt;
      pend_r      <= pend_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    idx_r        <= idx_nxt;
    ver_r        <= ver_nxt;
    ref_r        <= ref_nxt;
    scan_w_r     <= scan_w_nxt;
    pend_first_r <= pend_first_nxt;
    pend_w_r     <= pend_w_nxt;
    slot_k_r     <= slot_k_nxt;
    alloc_w_r    <= alloc_w_nxt;
    bm_mod_r     <= bm_mod_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ver_r    <= res_ver_nxt;
    res_ref_r    <= res_ref_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Used-slot bitmap
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_wa] <= bm_wd;
    end
    bm_rd_r <= bm_mem[bm_ra];
  end

  // Slot versions
  always_ff @(posedge clk) begin
    if (ver_we) begin
      ver_mem[ver_wa] <= ver_wd;
    end
    ver_rd_r <= ver_mem[ver_ra];
  end

  // Stored references
  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    ref_rd_r <= ref_mem[ref_ra];
  end

endmodule

[rtl/gha_checker.sv]
// ----------------------------------------------------------------------------
// Handle allocator port checker
// Watches the allocator's ports and flags handshake or result violations.
// ----------------------------------------------------------------------------
`include "generation_handle_allocator_defines.svh"

module gha_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [gha_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // A stalled result must hold its data.
  `GHA_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A failed request carries zeros in every field but the status.
  `GHA_ASSERT_SAME(a_fail_zero, out_tvalid && (out_tdata[gha_pkg::STATUS_W-1:0] != gha_pkg::ST_OK), out_tdata[gha_pkg::OUT_TDATA_W-1:gha_pkg::STATUS_W] == '0, "failed result has nonzero fields")

  // Only one request is worked on at a time.
  `GHA_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "request taken while another is in flight")

  // The clearing pass holds off requests right after reset.
  `GHA_ASSERT_SAME(a_clear_after_reset, !$past(rst_n), !in_tready, "request taken during clearing pass")

endmodule

bind generation_handle_allocator gha_checker u_gha_checker (.*);

[dv/generation_handle_allocator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Generation handle allocator testbench
// Drives allocate, release and lookup requests through the request stream
// and checks every result against an in-bench model of the slot table. A
// short table of directed requests comes first, then random handle traffic
// under three idling patterns, then a sweep that fills the table to the brim.
// ----------------------------------------------------------------------------
module generation_handle_allocator_test;
  import gha_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEF;
  // The block decodes the unused command code as a lookup.
  localparam logic [CMD_W-1:0] CMD_LOOKUP_ALT = 2'd3;

  typedef struct packed {
    status_t                status;
    logic [OUT_IDX_W-1:0]   slot;
    logic [VER_W-1:0]       gen;
    logic [REF_FIELD_W-1:0] tref;
  } handle_result_t;

  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic [SLOT_FIELD_W-1:0] idx;
    logic [VER_W-1:0]        ver;
    logic [REF_FIELD_W-1:0]  tref;
    bit                      typed;
    handle_result_t          res;
  } request_row_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  generation_handle_allocator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Model of the slot table.
  logic             slot_used [SLOTS];
  logic [VER_W-1:0] slot_gen  [SLOTS];
  logic [31:0]      slot_tref [SLOTS];
  int               next_fit_start;
  int               live_count;

  handle_result_t   pending_results[$];
  handle_result_t   want;
  request_row_t     directed_rows[$];
  int               err_count = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (err_count < 40)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp_val);
    err_count++;
  endtask

  function automatic handle_result_t err_result(status_t s);
    handle_result_t r;
    r = '0;
    r.status = s;
    return r;
  endfunction

  function automatic status_t handle_status(logic [SLOT_FIELD_W-1:0] idx,
                                            logic [VER_W-1:0] ver);
    if (idx >= SLOTS) return ST_RANGE;
    if (!slot_used[idx]) return ST_FREE;
    if (slot_gen[idx] != ver) return ST_STALE;
    return ST_OK;
  endfunction

  // Applies one request to the model and returns the result it should give.
  function automatic handle_result_t model_handle_op(logic [CMD_W-1:0] cmd,
                                                     logic [SLOT_FIELD_W-1:0] idx,
                                                     logic [VER_W-1:0] ver,
                                                     logic [REF_FIELD_W-1:0] tref);
    handle_result_t r;
    int k;
    r = '0;
    if (cmd == CMD_ALLOC) begin
      if (tref == '0) begin
        r.status = ST_NULL;
      end else begin
        r.status = ST_FULL;
        for (int n = 0; n < SLOTS; n++) begin
          k = (next_fit_start + n) % SLOTS;
          if (!slot_used[k]) begin
            slot_used[k] = 1'b1;
            slot_tref[k] = tref;
            next_fit_start = (k + 1) % SLOTS;
            live_count++;
            r.status = ST_OK;
            r.slot = k[OUT_IDX_W-1:0];
            r.gen = slot_gen[k];
            break;
          end
        end
      end
    end else if (cmd == CMD_RELEASE) begin
      r.status = handle_status(idx, ver);
      if (r.status == ST_OK) begin
        slot_used[idx] = 1'b0;
        slot_tref[idx] = '0;
        slot_gen[idx] = slot_gen[idx] + 1'b1;
        next_fit_start = idx;
        live_count--;
      end
    end else begin
      r.status = handle_status(idx, ver);
      if (r.status == ST_OK) r.tref = slot_tref[idx];
    end
    return r;
  endfunction

  // Returns a slot that holds a live handle, or -1 when the table is empty.
  function automatic int pick_live_slot();
    int k;
    k = $urandom_range(SLOTS - 1);
    for (int n = 0; n < SLOTS; n++) begin
      if (slot_used[(k + n) % SLOTS]) return (k + n) % SLOTS;
    end
    return -1;
  endfunction

  // Holds valid high across back-to-back transfers; valid only drops for a gap.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic [SLOT_FIELD_W-1:0] idx,
                              logic [VER_W-1:0] ver, logic [REF_FIELD_W-1:0] tref,
                              bit typed, handle_result_t typed_res);
    handle_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0, tref, ver, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = model_handle_op(cmd, idx, ver, tref);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic send_checked(logic [CMD_W-1:0] cmd, logic [SLOT_FIELD_W-1:0] idx,
                              logic [VER_W-1:0] ver, logic [REF_FIELD_W-1:0] tref);
    send_request(cmd, idx, ver, tref, 1'b0, '0);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random_request();
    int pick;
    int s;
    logic [31:0] tref;
    pick = $urandom_range(99);
    tref = $urandom;
    s = pick_live_slot();
    if (pick < 40 || s < 0) begin
      if ($urandom_range(19) == 0) tref = '0;
      send_checked(CMD_ALLOC, $urandom, $urandom, tref);
    end else if (pick < 65) begin
      send_checked(CMD_RELEASE, s, slot_gen[s], tref);
    end else if (pick < 85) begin
      send_checked(CMD_LOOKUP, s, slot_gen[s], tref);
    end else if (pick < 90) begin
      // A handle whose generation is off by some nonzero pattern.
      send_checked($urandom_range(1, 2), s, slot_gen[s] ^ $urandom_range(1, 32'hFFFF_FFFF),
                   tref);
    end else if (pick < 95) begin
      send_checked($urandom_range(3), $urandom, $urandom, tref);
    end else begin
      send_checked(CMD_LOOKUP_ALT, s, slot_gen[s], tref);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", out_tdata[31:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[2:0] !== want.status)
          report_mismatch("status", out_tdata[2:0], want.status);
        if (out_tdata[12:3] !== want.slot)
          report_mismatch("out_index", out_tdata[12:3], want.slot);
        if (out_tdata[44:13] !== want.gen)
          report_mismatch("out_version", out_tdata[44:13], want.gen);
        if (out_tdata[76:45] !== want.tref)
          report_mismatch("out_task_ref", out_tdata[76:45], want.tref);
      end
    end
  end

  initial begin
    int s;
    for (int i = 0; i < SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_gen[i]  = '0;
      slot_tref[i] = '0;
    end
    next_fit_start = 0;
    live_count = 0;

    directed_rows.push_back('{CMD_ALLOC, 12'd0, 32'd0, 32'd1, 1'b1,
                              '{ST_OK, 10'd0, 32'd0, 32'd0}});
    directed_rows.push_back('{CMD_ALLOC, 12'd0, 32'd0, 32'd0, 1'b1, err_result(ST_NULL)});
    directed_rows.push_back('{CMD_LOOKUP, 12'd0, 32'd0, 32'd0, 1'b1,
                              '{ST_OK, 10'd0, 32'd0, 32'd1}});
    directed_rows.push_back('{CMD_LOOKUP, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                              err_result(ST_RANGE)});
    directed_rows.push_back('{CMD_RELEASE, 12'd1024, 32'd0, 32'd0, 1'b1,
                              err_result(ST_RANGE)});
    directed_rows.push_back('{CMD_RELEASE, 12'd1023, 32'd0, 32'd0, 1'b1,
                              err_result(ST_FREE)});
    directed_rows.push_back('{CMD_LOOKUP, 12'd5, 32'd0, 32'd0, 1'b1, err_result(ST_FREE)});
    directed_rows.push_back('{CMD_RELEASE, 12'd0, 32'hFFFF_FFFF, 32'd0, 1'b1,
                              err_result(ST_STALE)});
    directed_rows.push_back('{CMD_LOOKUP_ALT, 12'd0, 32'd0, 32'd0, 1'b1,
                              '{ST_OK, 10'd0, 32'd0, 32'd1}});
    directed_rows.push_back('{CMD_RELEASE, 12'd0, 32'd0, 32'd0, 1'b1, err_result(ST_OK)});
    directed_rows.push_back('{CMD_LOOKUP, 12'd0, 32'd0, 32'd0, 1'b1, err_result(ST_FREE)});
    directed_rows.push_back('{CMD_ALLOC, 12'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0});
    directed_rows.push_back('{CMD_ALLOC, 12'hFFF, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, '0});
    directed_rows.push_back('{CMD_LOOKUP, 12'd0, 32'd1, 32'd0, 1'b0, '0});
    directed_rows.push_back('{CMD_LOOKUP, 12'd0, 32'd0, 32'd0, 1'b1, err_result(ST_STALE)});
    directed_rows.push_back('{CMD_ALLOC, 12'd0, 32'd0, 32'h5555_5555, 1'b0, '0});
    directed_rows.push_back('{CMD_ALLOC, 12'd0, 32'd0, 32'hAAAA_AAAA, 1'b0, '0});
    directed_rows.push_back('{CMD_LOOKUP, 12'd2, 32'd0, 32'd0, 1'b0, '0});
    directed_rows.push_back('{CMD_LOOKUP_ALT, 12'd3, 32'd0, 32'd0, 1'b0, '0});
    directed_rows.push_back('{CMD_RELEASE, 12'd1, 32'd0, 32'd0, 1'b0, '0});
    directed_rows.push_back('{CMD_ALLOC, 12'd0, 32'd0, 32'h0000_1234, 1'b0, '0});
    directed_rows.push_back('{CMD_RELEASE, 12'd2048, 32'd0, 32'd0, 1'b1,
                              err_result(ST_RANGE)});
    directed_rows.push_back('{CMD_LOOKUP_ALT, 12'hFFF, 32'd0, 32'd0, 1'b1,
                              err_result(ST_RANGE)});

    send_idle_pct = 36;
    recv_idle_pct = 73;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].cmd, directed_rows[i].idx, directed_rows[i].ver,
                   directed_rows[i].tref, directed_rows[i].typed, directed_rows[i].res);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 36 : 0;
      for (int n = 0; n < 200; n++) begin
        send_random_request();
        if ($urandom_range(39) == 0) wait_drained();
      end
      wait_drained();
    end

    // Fill every slot, then hit the full table and free slots on both sides of
    // the search start so that the next-fit scan has to wrap around.
    while (live_count < SLOTS)
      send_checked(CMD_ALLOC, $urandom, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
    send_checked(CMD_ALLOC, 12'd0, 32'd0, 32'hFFFF_FFFF);
    send_checked(CMD_RELEASE, 12'd5, slot_gen[5], 32'd0);
    send_checked(CMD_RELEASE, 12'd1020, slot_gen[1020], 32'd0);
    send_checked(CMD_ALLOC, 12'd0, 32'd0, 32'h0000_0001);
    send_checked(CMD_ALLOC, 12'd0, 32'd0, 32'h0000_0002);
    send_checked(CMD_LOOKUP, 12'd5, slot_gen[5], 32'd0);
    send_checked(CMD_RELEASE, 12'd1023, slot_gen[1023], 32'd0);
    send_checked(CMD_RELEASE, 12'd7, slot_gen[7], 32'd0);
    send_checked(CMD_ALLOC, 12'd0, 32'd0, 32'hFFFF_FFFF);
    send_checked(CMD_ALLOC, 12'd0, 32'd0, 32'h8000_0001);
    send_checked(CMD_ALLOC, 12'd0, 32'd0, 32'h0000_0003);
    for (int n = 0; n < 40; n++) begin
      s = pick_live_slot();
      send_checked(CMD_RELEASE, s, slot_gen[s], $urandom);
    end
    for (int n = 0; n < 60; n++) send_random_request();

    wait_drained();
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
